[rtl/core/rgb_to_hsi_pixel_assert.svh]
// Assertion macros for the rgb_to_hsi_pixel checker.
// Expects clk and rst in the scope where the macros are used.
`ifndef RGB_TO_HSI_PIXEL_ASSERT_SVH
`define RGB_TO_HSI_PIXEL_ASSERT_SVH

// same-cycle implication, off during reset
`define RHSI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhsi check failed");

// next-cycle implication, off during reset
`define RHSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhsi check failed");

// next-cycle implication, also checked through reset
`define RHSI_ASSERT_NEXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rhsi check failed");

`endif

[rtl/core/rhsi_pkg.sv]
// Shared constants, pipeline record type and CORDIC angle table
// for the RGB to HSI pixel converter. No dependencies.
`timescale 1ns / 1ps

package rhsi_pkg;

  localparam int CORDIC_STEPS = 22;
  localparam int DIV_BITS     = 8;
  localparam int XW           = 28;  // CORDIC vector component width
  localparam int AW           = 27;  // signed angle accumulator width

  localparam logic signed [AW-1:0] DEG180_Q16 = 27'sd11796480;
  localparam logic signed [AW-1:0] FULL_Q16   = 27'sd23592960;

  localparam logic [17:0] SQRT3_Q16  = 18'd113512;
  localparam logic [13:0] HUE_RECIP  = 14'd11651;  // ceil(2^19 / 45)
  localparam logic [9:0]  INT_RECIP  = 10'd683;    // ceil(2^11 / 3)
  localparam logic [9:0]  SAT_LOW    = 10'd61;
  localparam logic [9:0]  SAT_HIGH   = 10'd704;
  localparam logic [8:0]  GAIN_RESET = 9'd179;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic signed [AW-1:0] atan_q16(input int unsigned idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = 27'sd2949120;
      1:  v = 27'sd1740967;
      2:  v = 27'sd919879;
      3:  v = 27'sd466945;
      4:  v = 27'sd234379;
      5:  v = 27'sd117304;
      6:  v = 27'sd58666;
      7:  v = 27'sd29335;
      8:  v = 27'sd14668;
      9:  v = 27'sd7334;
      10: v = 27'sd3667;
      11: v = 27'sd1833;
      12: v = 27'sd917;
      13: v = 27'sd458;
      14: v = 27'sd229;
      15: v = 27'sd115;
      16: v = 27'sd57;
      17: v = 27'sd29;
      18: v = 27'sd14;
      19: v = 27'sd7;
      20: v = 27'sd4;
      21: v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [7:0]           r;
    logic [7:0]           g;
    logic [7:0]           b;
    logic [9:0]           sum;
    logic [7:0]           mn;
    logic                 gray;
    logic                 sat_ok;
    logic signed [10:0]   xd;     // 2r - g - b
    logic signed [8:0]    d;      // g - b
    logic                 neg;    // vector was mirrored, add 180 deg
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic signed [AW-1:0] acc;
    logic [17:0]          rem;
    logic [7:0]           quot;
    logic [18:0]          iprod;
    logic [7:0]           inten;
    logic [16:0]          ht;
    logic [7:0]           hue;
    logic [7:0]           sat;
  } pipe_t;

endpackage

[rtl/core/rhsi_if.sv]
// Valid/ready channel interfaces for pixels in and HSI results out.
// Depends on nothing.
`timescale 1ns / 1ps

interface rhsi_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rhsi_hsi_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] intensity;
  modport source (output valid, hue, saturation, intensity, input ready);
  modport sink (input valid, hue, saturation, intensity, output ready);
endinterface

[rtl/core/rhsi_cordic_step.sv]
// One CORDIC vectoring iteration with shift amount STEP.
// Depends on rhsi_pkg.
`timescale 1ns / 1ps

module rhsi_cordic_step #(
  parameter int STEP = 0
) (
  input  rhsi_pkg::pipe_t din,
  output rhsi_pkg::pipe_t dout
);
  import rhsi_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // shifts truncate toward zero
  assign xs = (din.cx < 0) ? -((-din.cx) >>> STEP) : (din.cx >>> STEP);
  assign ys = (din.cy < 0) ? -((-din.cy) >>> STEP) : (din.cy >>> STEP);

  always_comb begin
    dout = din;
    if (din.cy > 0) begin
      dout.cx  = din.cx + ys;
      dout.cy  = din.cy - xs;
      dout.acc = din.acc + atan_q16(STEP);
    end else begin
      dout.cx  = din.cx - ys;
      dout.cy  = din.cy + xs;
      dout.acc = din.acc - atan_q16(STEP);
    end
  end

endmodule

[rtl/core/rhsi_div_step.sv]
// One restoring-division step for the saturation quotient, bit BIT.
// Depends on rhsi_pkg.
`timescale 1ns / 1ps

module rhsi_div_step #(
  parameter int BIT = 0
) (
  input  rhsi_pkg::pipe_t din,
  output rhsi_pkg::pipe_t dout
);
  import rhsi_pkg::*;

  logic [17:0] dv;

  assign dv = 18'(din.sum) << BIT;

  always_comb begin
    dout = din;
    if (din.rem >= dv) begin
      dout.rem       = din.rem - dv;
      dout.quot[BIT] = 1'b1;
    end
  end

endmodule

[rtl/core/rgb_to_hsi_pixel.sv]
// RGB to HSI pixel converter: 27-stage pipeline, one pixel per clock unless hsi stalls.
// Depends on rhsi_pkg, rhsi_if, rhsi_cordic_step, rhsi_div_step.
// Pixels accepted on pix leave on hsi from the last stage; one is taken
// every clock while hsi is not stalled. The depth is set by the 22-step
// CORDIC that finds the hue angle, one iteration per stage, plus input,
// setup, angle fixup and hue scaling stages; the 8-bit saturation divide
// runs one bit per stage alongside it. Stages empty of a pixel fill while
// hsi is stalled, so up to 27 pixels are held. cfg_we writes the 9-bit
// intensity gain (1/256 units, reset 179) and is to be used while idle.
`timescale 1ns / 1ps

module rgb_to_hsi_pixel (
  input  logic       clk,
  input  logic       rst,
  rhsi_pix_if.sink   pix,
  rhsi_hsi_if.source hsi,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);
  import rhsi_pkg::*;

  localparam int S_PREP = 1;
  localparam int S_INIT = 2;
  localparam int S_COR0 = 3;
  localparam int S_FIX  = S_COR0 + CORDIC_STEPS;
  localparam int S_OUT  = S_FIX + 1;
  localparam int NS     = S_OUT + 1;

  pipe_t         st   [NS];
  pipe_t         nxt  [NS];
  logic [NS-1:0] vld;
  logic [NS-1:0] vin;
  logic [NS:0]   ld;
  logic [8:0]    gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  // a stage loads when it is empty or its content moves on
  assign ld[NS]    = hsi.ready;
  assign pix.ready = ld[0];
  assign vin[0]    = pix.valid;

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_stage
      assign ld[i] = !vld[i] || ld[i+1];
      if (i > 0) begin : g_vin
        assign vin[i] = vld[i-1];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (ld[i]) begin
          vld[i] <= vin[i];
        end
      end
      always_ff @(posedge clk) begin
        if (ld[i]) begin
          st[i] <= nxt[i];
        end
      end
    end
  endgenerate

  always_comb begin
    nxt[0]   = '0;
    nxt[0].r = pix.red;
    nxt[0].g = pix.green;
    nxt[0].b = pix.blue;
  end

  always_comb begin
    nxt[S_PREP]        = st[S_PREP-1];
    nxt[S_PREP].sum    = 10'(st[S_PREP-1].r) + 10'(st[S_PREP-1].g) + 10'(st[S_PREP-1].b);
    nxt[S_PREP].mn     = st[S_PREP-1].r;
    if (st[S_PREP-1].g < nxt[S_PREP].mn) begin
      nxt[S_PREP].mn = st[S_PREP-1].g;
    end
    if (st[S_PREP-1].b < nxt[S_PREP].mn) begin
      nxt[S_PREP].mn = st[S_PREP-1].b;
    end
    nxt[S_PREP].gray   = (st[S_PREP-1].r == st[S_PREP-1].g)
                      && (st[S_PREP-1].g == st[S_PREP-1].b);
    nxt[S_PREP].sat_ok = (nxt[S_PREP].sum > SAT_LOW) && (nxt[S_PREP].sum < SAT_HIGH);
    nxt[S_PREP].xd     = $signed({2'b00, st[S_PREP-1].r, 1'b0})
                       - $signed({3'b000, st[S_PREP-1].g})
                       - $signed({3'b000, st[S_PREP-1].b});
    nxt[S_PREP].d      = $signed({1'b0, st[S_PREP-1].g}) - $signed({1'b0, st[S_PREP-1].b});
  end

  logic signed [XW-1:0] init_x;
  logic signed [XW-1:0] init_y;
  logic [9:0]           init_diff;

  always_comb begin
    init_x    = XW'(st[S_INIT-1].xd) <<< 16;
    init_y    = XW'(st[S_INIT-1].d * $signed({1'b0, SQRT3_Q16}));
    init_diff = st[S_INIT-1].sum - 10'(3 * st[S_INIT-1].mn);
    nxt[S_INIT]      = st[S_INIT-1];
    nxt[S_INIT].neg  = st[S_INIT-1].xd < 0;
    nxt[S_INIT].cx   = nxt[S_INIT].neg ? -init_x : init_x;
    nxt[S_INIT].cy   = nxt[S_INIT].neg ? -init_y : init_y;
    nxt[S_INIT].acc  = '0;
    // 255 * (sum - 3 * min)
    nxt[S_INIT].rem  = {init_diff, 8'b0} - 18'(init_diff);
    nxt[S_INIT].quot = '0;
    nxt[S_INIT].iprod = 19'(st[S_INIT-1].sum * gain);
  end

  pipe_t cor [CORDIC_STEPS];

  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      rhsi_cordic_step #(.STEP(i)) u_cordic (
        .din  (st[S_COR0+i-1]),
        .dout (cor[i])
      );
      if (i < DIV_BITS) begin : g_div
        rhsi_div_step #(.BIT(DIV_BITS-1-i)) u_div (
          .din  (cor[i]),
          .dout (nxt[S_COR0+i])
        );
      end else if (i == DIV_BITS) begin : g_int
        logic [10:0] it;
        logic [20:0] ip;
        // floor(sum * gain / 768) = floor((p >> 8) / 3)
        always_comb begin
          it = cor[i].iprod[18:8];
          ip = it * INT_RECIP;
          nxt[S_COR0+i]       = cor[i];
          nxt[S_COR0+i].inten = (ip[20:11] > 10'd255) ? 8'd255 : ip[18:11];
        end
      end else begin : g_pass
        assign nxt[S_COR0+i] = cor[i];
      end
    end
  endgenerate

  logic signed [AW-1:0] ang;
  logic [24:0]          ang_u;
  logic [32:0]          ang_p;

  always_comb begin
    ang = st[S_FIX-1].acc + (st[S_FIX-1].neg ? DEG180_Q16 : '0);
    if (ang < 0) begin
      ang = ang + FULL_Q16;
    end
    if (ang >= FULL_Q16) begin
      ang = ang - FULL_Q16;
    end
    if (st[S_FIX-1].gray) begin
      ang = '0;
    end else if (st[S_FIX-1].d == 0) begin
      ang = (st[S_FIX-1].xd > 0) ? '0 : DEG180_Q16;
    end
    ang_u = ang[24:0];
    ang_p = {ang_u, 8'b0} - 33'(ang_u);
    nxt[S_FIX]    = st[S_FIX-1];
    nxt[S_FIX].ht = ang_p[32:16];
  end

  logic [27:0] hue_p;

  // floor(ht / 360) = floor((ht >> 3) / 45)
  always_comb begin
    hue_p = st[S_OUT-1].ht[16:3] * HUE_RECIP;
    nxt[S_OUT]     = st[S_OUT-1];
    nxt[S_OUT].hue = (hue_p[27:19] > 9'd255) ? 8'd255 : hue_p[26:19];
    nxt[S_OUT].sat = st[S_OUT-1].sat_ok ? st[S_OUT-1].quot : 8'd0;
  end

  assign hsi.valid      = vld[S_OUT];
  assign hsi.hue        = st[S_OUT].hue;
  assign hsi.saturation = st[S_OUT].sat;
  assign hsi.intensity  = st[S_OUT].inten;

endmodule

[rtl/core/rhsi_checker.sv]
// Port-level checks for rgb_to_hsi_pixel, bound to the top level.
// Depends on rgb_to_hsi_pixel_assert.svh and rgb_to_hsi_pixel.
`timescale 1ns / 1ps

module rhsi_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] hue,
  input logic [7:0] saturation,
  input logic [7:0] intensity
);
`include "rgb_to_hsi_pixel_assert.svh"

  // a stalled result transaction holds
  `RHSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hue) && $stable(saturation) && $stable(intensity))
  // a free output drains the whole pipe, so input is never blocked
  `RHSI_ASSERT_NOW(a_in_free, out_ready, in_ready)
  // a blocked input transaction stays offered
  `RHSI_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)
  // reset empties the pipe
  `RHSI_ASSERT_NEXT_ALL(a_rst_empty, rst, !out_valid)

endmodule

bind rgb_to_hsi_pixel rhsi_checker u_rhsi_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix.valid),
  .in_ready   (pix.ready),
  .out_valid  (hsi.valid),
  .out_ready  (hsi.ready),
  .hue        (hsi.hue),
  .saturation (hsi.saturation),
  .intensity  (hsi.intensity)
);
